// File: hdl/differential_drive_odometry_defines.svh
// Assertion macros shared by the odometry RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DDO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("odometry check failed");
// Condition must never be seen outside reset.
`define DDO_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("odometry forbidden condition seen");
`else
`define DDO_ASSERT(lbl, clk, rstn, prop)
`define DDO_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hdl/ddo_pkg.sv
`timescale 1ns / 1ps
// Shared constants, opcodes and the CORDIC arctangent table for the odometry block.
// No dependencies; imported by ddo_cordic and differential_drive_odometry.
package ddo_pkg;

  localparam int FracBitsDef    = 16;
  localparam int CordicItersDef = 18;
  localparam int AtanEntries    = 24;

  localparam int OpW    = 3;
  localparam int CountW = 16;
  localparam int PosW   = 48;
  localparam int HeadW  = 13;
  localparam int AngW   = 33;   // Q2.30 sine/cosine and binary angle, signed
  localparam int IterW  = 5;
  localparam int ProdW  = CountW + AngW;
  localparam int HsumW  = 18;
  localparam int RemW   = 11;   // remainder within a quarter turn, 0..1249

  localparam logic [OpW-1:0] OpForward  = 3'd0;
  localparam logic [OpW-1:0] OpBackward = 3'd1;
  localparam logic [OpW-1:0] OpRotLeft  = 3'd2;
  localparam logic [OpW-1:0] OpRotRight = 3'd3;
  localparam logic [OpW-1:0] OpReset    = 3'd4;

  localparam logic [HeadW-1:0] HeadMod  = 13'd5000;
  localparam logic [HeadW-1:0] Quarter  = 13'd1250;
  localparam logic [HsumW-1:0] HeadBias = 18'd70000;   // 14 full turns

  localparam logic [14:0] DistMax = 15'd32767;

  localparam logic signed [AngW-1:0] GainQ30 = 33'sd652032874;

  // theta = r * floor(2^30/1250) + floor(r * (2^30 mod 1250) / 1250)
  localparam logic [19:0] QuarterStep  = 20'd858993;
  localparam logic [9:0]  QuarterRem   = 10'd574;
  localparam logic [19:0] QuarterInvQ30 = 20'd858994;  // ceil(2^30/1250)

  // arctan(2^-i), full turn = 2^32
  function automatic logic [29:0] atan_lut(input logic [IterW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Forward/backward moves step through angle split, reciprocal, theta, the
// iterative CORDIC and the X and Y multiply-accumulate; rotations run five
// conditional subtracts for the modulo; reset pose and unused opcodes go straight to output.
// One word at a time: the next word is taken once the result is registered, and
// the result waits in S_DONE while the output register is still full.
// Reset: asynchronous, active low; pose, heading and output valid clear to zero.
`include "differential_drive_odometry_defines.svh"

module differential_drive_odometry #(
  parameter int FRAC_BITS    = ddo_pkg::FracBitsDef,
  parameter int CORDIC_ITERS = ddo_pkg::CordicItersDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ddo_pkg::OpW-1:0]            opcode_i,
  input  logic signed [ddo_pkg::CountW-1:0]  left_count_i,
  input  logic signed [ddo_pkg::CountW-1:0]  right_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ddo_pkg::PosW-1:0]    pos_x_o,
  output logic signed [ddo_pkg::PosW-1:0]    pos_y_o,
  output logic [ddo_pkg::HeadW-1:0]          heading_units_o
);
  import ddo_pkg::*;

  localparam int Iters    = (CORDIC_ITERS < AtanEntries) ? CORDIC_ITERS : AtanEntries;
  localparam int ShiftAmt = 30 - FRAC_BITS;
  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1) <<< (ShiftAmt - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_ANGLE, S_RECIP, S_THETA, S_CORDIC, S_MULX, S_ADDX, S_ADDY, S_DONE
  } state_e;

  state_e                  state_q;
  logic                    out_valid_q;
  logic [PosW-1:0]         x_acc_q, y_acc_q;
  logic [HeadW-1:0]        heading_q;
  logic [PosW-1:0]         pos_x_q, pos_y_q;
  logic [HeadW-1:0]        heading_out_q;
  logic signed [CountW-1:0] dist_q;
  logic [HsumW-1:0]        hsum_q;
  logic [2:0]              step_q;
  logic [1:0]              quad_q;
  logic [RemW-1:0]         rem_q;
  logic [19:0]             t_q;
  logic [9:0]              lo_q;
  logic signed [AngW-1:0]  sn_q, cs_q;
  logic signed [ProdW-1:0] prod_q;

  logic                    in_acc;
  logic signed [CountW:0]  l_ext, r_ext;
  logic [CountW:0]         l_mag, r_mag;
  logic [CountW+1:0]       mag_sum;
  logic [14:0]             avg_sat;
  logic signed [CountW-1:0] dist_d;
  logic [HsumW-1:0]        hsum_in, mod_sub, hsum_nxt;
  logic [1:0]              quad_d;
  logic [HeadW-1:0]        rem_full;
  logic [39:0]             lo_full;
  logic [30:0]             hi_d;
  logic signed [AngW-1:0]  theta_d;
  logic                    cordic_start, cordic_done;
  logic signed [AngW-1:0]  cordic_cos, cordic_sin;
  logic signed [AngW-1:0]  mul_src;
  logic signed [ProdW-1:0] prod_d;

  function automatic logic [PosW-1:0] round_scale(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = (p + RndHalf) >>> ShiftAmt;
    return s[PosW-1:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // distance: truncated mean of step magnitudes, saturated
  assign l_ext   = (CountW+1)'(left_count_i);
  assign r_ext   = (CountW+1)'(right_count_i);
  assign l_mag   = l_ext[CountW] ? (CountW+1)'(-l_ext) : (CountW+1)'(l_ext);
  assign r_mag   = r_ext[CountW] ? (CountW+1)'(-r_ext) : (CountW+1)'(r_ext);
  assign mag_sum = (CountW+2)'(l_mag) + (CountW+2)'(r_mag);
  assign avg_sat = (mag_sum[CountW+1:1] > (CountW+1)'(DistMax)) ? DistMax
                                                                 : mag_sum[15:1];
  assign dist_d  = (opcode_i == OpBackward) ? -$signed({1'b0, avg_sat})
                                            : $signed({1'b0, avg_sat});

  // heading plus bias stays positive, then reduce by 5000 * 2^k, k = 4..0
  assign hsum_in  = HsumW'(heading_q) + HeadBias + HsumW'(r_ext) - HsumW'(l_ext);
  assign mod_sub  = HsumW'(HeadMod) << step_q;
  assign hsum_nxt = (hsum_q >= mod_sub) ? (hsum_q - mod_sub) : hsum_q;

  // split heading into quadrant and remainder
  always_comb begin
    if (heading_q >= 3 * Quarter) begin
      quad_d   = 2'd3;
      rem_full = heading_q - HeadW'(3 * Quarter);
    end else if (heading_q >= 2 * Quarter) begin
      quad_d   = 2'd2;
      rem_full = heading_q - HeadW'(2 * Quarter);
    end else if (heading_q >= Quarter) begin
      quad_d   = 2'd1;
      rem_full = heading_q - Quarter;
    end else begin
      quad_d   = 2'd0;
      rem_full = heading_q;
    end
  end

  assign lo_full = 40'(t_q) * 40'(QuarterInvQ30);
  assign hi_d    = 31'(rem_q) * 31'(QuarterStep);
  assign theta_d = $signed(AngW'(hi_d) + AngW'(lo_q));

  assign cordic_start = (state_q == S_THETA);

  ddo_cordic #(
    .ITERS (Iters)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .theta_i (theta_d),
    .done_o  (cordic_done),
    .cos_o   (cordic_cos),
    .sin_o   (cordic_sin)
  );

  assign mul_src = (state_q == S_MULX) ? sn_q : cs_q;
  assign prod_d  = ProdW'(dist_q) * ProdW'(mul_src);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      x_acc_q       <= '0;
      y_acc_q       <= '0;
      heading_q     <= '0;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      heading_out_q <= '0;
      dist_q        <= '0;
      hsum_q        <= '0;
      step_q        <= '0;
      quad_q        <= '0;
      rem_q         <= '0;
      t_q           <= '0;
      lo_q          <= '0;
      sn_q          <= '0;
      cs_q          <= '0;
      prod_q        <= '0;
    end else begin
      if (out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            dist_q <= dist_d;
            hsum_q <= hsum_in;
            step_q <= 3'd4;
            if (opcode_i == OpForward || opcode_i == OpBackward) begin
              state_q <= S_ANGLE;
            end else if (opcode_i == OpRotLeft || opcode_i == OpRotRight) begin
              state_q <= S_MOD;
            end else if (opcode_i == OpReset) begin
              x_acc_q   <= '0;
              y_acc_q   <= '0;
              heading_q <= '0;
              state_q   <= S_DONE;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_MOD: begin
          hsum_q <= hsum_nxt;
          if (step_q == 3'd0) begin
            heading_q <= hsum_nxt[HeadW-1:0];
            state_q   <= S_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_ANGLE: begin
          quad_q  <= quad_d;
          rem_q   <= rem_full[RemW-1:0];
          t_q     <= 20'(rem_full[RemW-1:0]) * 20'(QuarterRem);
          state_q <= S_RECIP;
        end
        S_RECIP: begin
          lo_q    <= lo_full[39:30];
          state_q <= S_THETA;
        end
        S_THETA: begin
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cordic_done) begin
            case (quad_q)
              2'd0: begin
                sn_q <= cordic_sin;
                cs_q <= cordic_cos;
              end
              2'd1: begin
                sn_q <= cordic_cos;
                cs_q <= -cordic_sin;
              end
              2'd2: begin
                sn_q <= -cordic_sin;
                cs_q <= -cordic_cos;
              end
              default: begin
                sn_q <= -cordic_cos;
                cs_q <= cordic_sin;
              end
            endcase
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          prod_q  <= prod_d;
          state_q <= S_ADDX;
        end
        S_ADDX: begin
          x_acc_q <= x_acc_q + round_scale(prod_q);
          prod_q  <= prod_d;
          state_q <= S_ADDY;
        end
        S_ADDY: begin
          y_acc_q <= y_acc_q + round_scale(prod_q);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            pos_x_q       <= x_acc_q;
            pos_y_q       <= y_acc_q;
            heading_out_q <= heading_q;
            out_valid_q   <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = $signed(pos_x_q);
  assign pos_y_o         = $signed(pos_y_q);
  assign heading_units_o = heading_out_q;

  `DDO_ASSERT_NEVER(a_heading_range, clk_i, rst_ni, heading_q >= HeadMod)
  `DDO_ASSERT(a_accept_busy, clk_i, rst_ni, in_acc |=> (state_q != S_IDLE))
  `DDO_ASSERT(a_cordic_owner, clk_i, rst_ni, cordic_done |-> (state_q == S_CORDIC))
  `DDO_ASSERT(a_mod_bound, clk_i, rst_ni, (state_q == S_MOD) |-> (hsum_q < (mod_sub << 1)))

endmodule

// File: hdl/ddo_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30 output.
// Depends on ddo_pkg and differential_drive_odometry_defines.svh.
`include "differential_drive_odometry_defines.svh"

module ddo_cordic #(
  parameter int ITERS = ddo_pkg::CordicItersDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ddo_pkg::AngW-1:0]  theta_i,
  output logic                             done_o,
  output logic signed [ddo_pkg::AngW-1:0]  cos_o,
  output logic signed [ddo_pkg::AngW-1:0]  sin_o
);
  import ddo_pkg::*;

  localparam logic [IterW-1:0] LastIter = IterW'(ITERS - 1);

  logic                   busy_q;
  logic                   done_q;
  logic [IterW-1:0]       iter_q;
  logic signed [AngW-1:0] x_q, y_q, z_q;
  logic signed [AngW-1:0] x_sh, y_sh, atan_v;

  assign x_sh   = x_q >>> iter_q;
  assign y_sh   = y_q >>> iter_q;
  assign atan_v = $signed(AngW'(atan_lut(iter_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
        x_q    <= GainQ30;
        y_q    <= '0;
        z_q    <= theta_i;
      end else if (busy_q) begin
        // rotate towards zero residual angle
        if (!z_q[AngW-1]) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_v;
        end
        if (iter_q == LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

  `DDO_ASSERT(a_no_restart, clk_i, rst_ni, start_i |-> !busy_q)
  `DDO_ASSERT(a_done_from_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `DDO_ASSERT_NEVER(a_iter_range, clk_i, rst_ni, iter_q > LastIter)

endmodule
